FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros: assertion helpers shared by the RTL
// Clocked implication checks, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/plob_pkg.sv
// ---------------------------------------------------------------------------
// plob_pkg: shared constants, types and encoders
// Sizes of the order and level tables, status codes and bitmap searches.
// ---------------------------------------------------------------------------
package plob_pkg;

  localparam int ORDER_SLOTS  = 1024;
  localparam int PRICE_LEVELS = 1024;
  localparam int ID_W    = 10;
  localparam int PRICE_W = 10;
  localparam int QTY_W   = 20;
  localparam int TOT_W   = 30;
  localparam int MID_W   = 11;
  localparam int SLOT_W  = $clog2(ORDER_SLOTS);
  localparam int LVL_W   = $clog2(PRICE_LEVELS);
  localparam int BIT_W   = 5;
  localparam int WORD_BITS = 1 << BIT_W;
  localparam int OCC_WORDS = PRICE_LEVELS / WORD_BITS;
  localparam int WIDX_W  = $clog2(OCC_WORDS);
  localparam int REC_W   = 1 + 1 + PRICE_W + QTY_W;
  localparam int CLR_W   = LVL_W + 1;

  localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_CANCEL = 1'b1;
  localparam logic SIDE_BID   = 1'b0;
  localparam logic SIDE_ASK   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_DUP     = 2'd2
  } status_t;

  typedef struct packed {
    logic               live;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } order_rec_t;

  function automatic logic [WIDX_W-1:0] hi_word(input logic [OCC_WORDS-1:0] v);
    logic [WIDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < OCC_WORDS; i++) if (v[i]) r = WIDX_W'(i);
    return r;
  endfunction

  function automatic logic [WIDX_W-1:0] lo_word(input logic [OCC_WORDS-1:0] v);
    logic [WIDX_W-1:0] r;
    r = '0;
    for (int i = OCC_WORDS - 1; i >= 0; i--) if (v[i]) r = WIDX_W'(i);
    return r;
  endfunction

  function automatic logic [BIT_W-1:0] hi_bit(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_BITS; i++) if (v[i]) r = BIT_W'(i);
    return r;
  endfunction

  function automatic logic [BIT_W-1:0] lo_bit(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) if (v[i]) r = BIT_W'(i);
    return r;
  endfunction

endpackage

FILE: rtl/core/plob_ram.sv
// ---------------------------------------------------------------------------
// plob_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module plob_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/price_level_order_book.sv
// ---------------------------------------------------------------------------
// price_level_order_book: limit order book with per-level totals
// Order table, level totals and occupancy bitmaps held in synchronous RAM.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one order message per transfer. s_tuser carries the
//   action (add or cancel); s_tdata carries id, side, price and quantity.
//   Output stream m_*: one result per message. m_tuser carries the status;
//   m_tdata carries presence flags, best bid, best ask and mid in half ticks.
//   Each message passes these steps from transfer to result in the output
//   register: order record back and level read, level write-back, then
//   best-price search (word summary encode, occupancy word read and encode).
//   The next transfer is taken in the idle state, once the previous result
//   has been loaded into the output register.
//   After reset the block sweeps its RAMs (one level entry a cycle) with
//   s_tready low. A new message is taken while a result still waits; if
//   the receiver stalls, the next result holds in the search stage until
//   the output register frees up.
// ---------------------------------------------------------------------------
module price_level_order_book (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // id[9:0], side[10], price[20:11], quantity[40:21]
  input  logic [0:0]  s_tuser,  // action[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // has_bid[0], has_ask[1], top bid[11:2],
                                // top ask[21:12], mid_half_ticks[32:22]
  output logic [1:0]  m_tuser   // status[1:0]
);
  import plob_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_LVL   = 6'b000100,
    S_UPD   = 6'b001000,
    S_BB    = 6'b010000,
    S_BW    = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [CLR_W-1:0] clr_cnt;

  logic               in_act;
  logic [ID_W-1:0]    in_id;
  logic               in_side;
  logic [PRICE_W-1:0] in_price;
  logic [QTY_W-1:0]   in_qty;

  logic               act_q;
  logic [SLOT_W-1:0]  id_q;
  logic               side_q;
  logic [PRICE_W-1:0] price_q;
  logic [QTY_W-1:0]   qty_q;
  logic               ok_q;
  status_t            status_q;
  logic [LVL_W-1:0]   lvl_q;
  logic               lside_q;
  logic [QTY_W-1:0]   lqty_q;

  logic [OCC_WORDS-1:0] bid_sum, ask_sum;

  order_rec_t ord_rd, ord_wd;
  logic       ord_we;
  logic [SLOT_W-1:0] ord_wa;
  logic [TOT_W-1:0] tot_rd, tot_wd, tot_new;
  logic       tot_we;
  logic [LVL_W:0] tot_wa, tot_ra;
  logic [WORD_BITS-1:0] occa_rd, occb_rd, occ_wd, occ_new;
  logic       occ_we;
  logic [WIDX_W:0] occ_wa, occa_ra, occb_ra;

  logic accept, load_out, lvl_ok, lvl_side;
  logic [LVL_W-1:0] lvl_addr;
  logic [QTY_W-1:0] lvl_qty;
  status_t lvl_status;
  logic [TOT_W:0] sum_ext;
  logic occ_bit;
  logic [WIDX_W-1:0] bw, aw;
  logic hb, ha;
  logic [PRICE_W-1:0] bb, ba;
  logic [MID_W-1:0] mid;

  assign in_act   = s_tuser[0];
  assign in_id    = s_tdata[9:0];
  assign in_side  = s_tdata[10];
  assign in_price = s_tdata[20:11];
  assign in_qty   = s_tdata[40:21];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign load_out = (state == S_BW) && (!m_tvalid || m_tready);

  // Decide on the item once its order record is back.
  always_comb begin
    lvl_status = ST_OK;
    lvl_ok     = 1'b1;
    lvl_side   = side_q;
    lvl_addr   = price_q[LVL_W-1:0];
    lvl_qty    = qty_q;
    if (act_q == ACT_ADD) begin
      if (ord_rd.live) begin
        lvl_status = ST_DUP;
        lvl_ok     = 1'b0;
      end
    end else begin
      lvl_side = ord_rd.side;
      lvl_addr = ord_rd.price[LVL_W-1:0];
      lvl_qty  = ord_rd.qty;
      if (!ord_rd.live) begin
        lvl_status = ST_UNKNOWN;
        lvl_ok     = 1'b0;
      end
    end
  end

  // Saturating add or clamped subtract on the level total.
  always_comb begin
    sum_ext = {1'b0, tot_rd} + {{(TOT_W + 1 - QTY_W){1'b0}}, lqty_q};
    if (act_q == ACT_ADD) begin
      tot_new = (sum_ext > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum_ext[TOT_W-1:0];
    end else begin
      tot_new = ({{(TOT_W - QTY_W){1'b0}}, lqty_q} >= tot_rd) ? '0
              : tot_rd - {{(TOT_W - QTY_W){1'b0}}, lqty_q};
    end
    occ_bit = (tot_new != '0);
    occ_new = occa_rd;
    occ_new[lvl_q[BIT_W-1:0]] = occ_bit;
  end

  // RAM port control.
  always_comb begin
    ord_we = 1'b0;
    ord_wa = id_q;
    ord_wd = '0;
    tot_we = 1'b0;
    tot_wa = {lside_q, lvl_q};
    tot_wd = tot_new;
    occ_we = 1'b0;
    occ_wa = {lside_q, lvl_q[LVL_W-1:BIT_W]};
    occ_wd = occ_new;
    case (state)
      S_CLEAR: begin
        ord_we = 1'b1;
        ord_wa = clr_cnt[SLOT_W-1:0];
        tot_we = 1'b1;
        tot_wa = clr_cnt[LVL_W:0];
        tot_wd = '0;
        occ_we = 1'b1;
        occ_wa = clr_cnt[WIDX_W:0];
        occ_wd = '0;
      end
      S_LVL: begin
        ord_we = lvl_ok;
        if (act_q == ACT_ADD) begin
          ord_wd = '{live: 1'b1, side: side_q, price: price_q, qty: qty_q};
        end else begin
          ord_wd = ord_rd;
          ord_wd.live = 1'b0;
        end
      end
      S_UPD: begin
        tot_we = ok_q;
        occ_we = ok_q;
      end
      default: begin
      end
    endcase
  end

  assign tot_ra  = {lvl_side, lvl_addr};
  assign bw      = hi_word(bid_sum);
  assign aw      = lo_word(ask_sum);
  assign occa_ra = (state == S_LVL) ? {lvl_side, lvl_addr[LVL_W-1:BIT_W]} : {SIDE_BID, bw};
  assign occb_ra = {SIDE_ASK, aw};

  plob_ram #(.WIDTH(REC_W), .DEPTH(ORDER_SLOTS)) u_ord (
    .clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd),
    .raddr(in_id[SLOT_W-1:0]), .rdata(ord_rd)
  );

  plob_ram #(.WIDTH(TOT_W), .DEPTH(2 * PRICE_LEVELS)) u_tot (
    .clk(clk), .we(tot_we), .waddr(tot_wa), .wdata(tot_wd),
    .raddr(tot_ra), .rdata(tot_rd)
  );

  plob_ram #(.WIDTH(WORD_BITS), .DEPTH(2 * OCC_WORDS)) u_occa (
    .clk(clk), .we(occ_we), .waddr(occ_wa), .wdata(occ_wd),
    .raddr(occa_ra), .rdata(occa_rd)
  );

  plob_ram #(.WIDTH(WORD_BITS), .DEPTH(2 * OCC_WORDS)) u_occb (
    .clk(clk), .we(occ_we), .waddr(occ_wa), .wdata(occ_wd),
    .raddr(occb_ra), .rdata(occb_rd)
  );

  // Best prices from summaries and the words just read.
  always_comb begin
    hb  = |bid_sum;
    ha  = |ask_sum;
    bb  = hb ? PRICE_W'({bw, hi_bit(occa_rd)}) : '0;
    ba  = ha ? PRICE_W'({aw, lo_bit(occb_rd)}) : '0;
    mid = (hb && ha) ? ({1'b0, bb} + {1'b0, ba}) : '0;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_cnt == {CLR_W{1'b1}}) state_next = S_IDLE;
      S_IDLE:  if (accept) state_next = S_LVL;
      S_LVL:   state_next = S_UPD;
      S_UPD:   state_next = S_BB;
      S_BB:    state_next = S_BW;
      S_BW:    if (load_out) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      bid_sum  <= '0;
      ask_sum  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      // Keep the word summary in step with the word written back.
      if ((state == S_UPD) && ok_q) begin
        if (lside_q == SIDE_BID) begin
          bid_sum[lvl_q[LVL_W-1:BIT_W]] <= |occ_new;
        end else begin
          ask_sum[lvl_q[LVL_W-1:BIT_W]] <= |occ_new;
        end
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_q   <= in_act;
      id_q    <= in_id[SLOT_W-1:0];
      side_q  <= in_side;
      price_q <= in_price;
      qty_q   <= in_qty;
    end
    if (state == S_LVL) begin
      ok_q     <= lvl_ok;
      status_q <= lvl_status;
      lvl_q    <= lvl_addr;
      lside_q  <= lvl_side;
      lqty_q   <= lvl_qty;
    end
    if (load_out) begin
      m_tuser <= status_q;
      m_tdata <= {7'd0, mid, ba, bb, ha, hb};
    end
  end

  `ASSERT_IMPL(a_no_accept_in_clear, clk, rst, state == S_CLEAR, !s_tready)
  `ASSERT_NEXT(a_accept_to_lookup, clk, rst, accept, state == S_LVL)
  `ASSERT_NEXT(a_load_gives_valid, clk, rst, load_out, m_tvalid)
  `ASSERT_IMPL(a_mid_needs_both, clk, rst, m_tvalid && !(m_tdata[0] && m_tdata[1]),
               m_tdata[32:22] == '0)

endmodule
